/* design/ppe_pkg.sv */
package ppe_pkg;

  localparam int MAX_DIM     = 1024;
  localparam int DIM_W       = $clog2(MAX_DIM) + 1;
  localparam int CNT_W       = $clog2(MAX_DIM);
  localparam int PAL_DEPTH   = 256;
  localparam int PAL_AW      = $clog2(PAL_DEPTH);
  localparam int COLOR_W     = 16;
  localparam int QUEUE_DEPTH = 2;

  localparam logic OP_PIXEL_DATA    = 1'b0;
  localparam logic OP_PALETTE_WRITE = 1'b1;

  localparam logic [1:0] DEPTH_1BPP = 2'd0;
  localparam logic [1:0] DEPTH_2BPP = 2'd1;
  localparam logic [1:0] DEPTH_4BPP = 2'd2;
  localparam logic [1:0] DEPTH_8BPP = 2'd3;

  localparam logic [1:0] REG_DEPTH_MODE  = 2'd0;
  localparam logic [1:0] REG_RECT_WIDTH  = 2'd1;
  localparam logic [1:0] REG_RECT_HEIGHT = 2'd2;

  typedef struct packed {
    logic               operation;
    logic [7:0]         data_byte;
    logic [7:0]         palette_index;
    logic [COLOR_W-1:0] palette_color;
  } in_word_t;

  typedef struct packed {
    logic [COLOR_W-1:0] pixel_color;
    logic               last_of_byte;
    logic               row_end;
    logic               frame_end;
  } out_word_t;

  // classified queue entry
  typedef struct packed {
    logic               is_palette;
    logic [7:0]         pixel_byte;
    logic [PAL_AW-1:0]  pal_addr;
    logic [COLOR_W-1:0] pal_color;
  } item_t;

  typedef struct packed {
    logic [1:0]       depth_mode;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } cfg_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end
    return r;
  endfunction

endpackage

/* design/ppe_front.sv */
module ppe_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  ppe_pkg::in_word_t in_word,
  output logic              head_valid,
  output ppe_pkg::item_t    head_item,
  input  logic              head_pop
);
  import ppe_pkg::*;

  localparam int QA_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

  item_t            q [QUEUE_DEPTH];
  logic [QA_W-1:0]  wr_ptr;
  logic [QA_W-1:0]  rd_ptr;
  logic [QC_W-1:0]  count;
  logic [QC_W-1:0]  count_next;
  logic             push;
  logic             pop;
  item_t            cls;

  assign in_stall   = (count == QC_W'(QUEUE_DEPTH));
  assign push       = in_valid && !in_stall;
  assign head_valid = (count != '0);
  assign pop        = head_pop && head_valid;
  assign head_item  = q[rd_ptr];

  // classify: keep only the fields that the item kind uses
  always_comb begin
    cls = '0;
    if (in_word.operation == OP_PALETTE_WRITE) begin
      cls.is_palette = 1'b1;
      cls.pal_addr   = PAL_AW'(in_word.palette_index);
      cls.pal_color  = in_word.palette_color;
    end else begin
      cls.pixel_byte = in_word.data_byte;
    end
  end

  always_comb begin
    case ({push, pop})
      2'b10:   count_next = count + 1'b1;
      2'b01:   count_next = count - 1'b1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QA_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QA_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QC_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");
`endif

endmodule

/* design/ppe_back.sv */
module ppe_back (
  input  logic               clk,
  input  logic               rst,
  input  ppe_pkg::cfg_t      cfg,
  input  logic               head_valid,
  input  ppe_pkg::item_t     head_item,
  output logic               head_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output ppe_pkg::out_word_t out_word
);
  import ppe_pkg::*;

  logic [COLOR_W-1:0] pal_mem [PAL_DEPTH];

  logic [2:0]         pix_k;
  logic [CNT_W-1:0]   col;
  logic [CNT_W-1:0]   row;
  logic               ov;
  logic [COLOR_W-1:0] rd_color;
  logic               lob_q;
  logic               rend_q;
  logic               fend_q;

  logic               advance;
  logic               fire;
  logic [5:0]         kbits;
  logic [7:0]         shifted;
  logic [PAL_AW-1:0]  idx;
  logic [2:0]         last_k;
  logic               rend;
  logic               fend;
  logic               lob;

  assign advance = !ov || !out_stall;
  assign fire    = head_valid && !head_item.is_palette && advance;

  // bit offset of the current field within the byte
  assign kbits   = 6'(pix_k) << cfg.depth_mode;
  assign shifted = head_item.pixel_byte << kbits;
  assign last_k  = 3'(3'd7 >> cfg.depth_mode);

  always_comb begin
    unique case (cfg.depth_mode)
      DEPTH_1BPP: idx = PAL_AW'(shifted[7]);
      DEPTH_2BPP: idx = PAL_AW'(shifted[7:6]);
      DEPTH_4BPP: idx = PAL_AW'(shifted[7:4]);
      DEPTH_8BPP: idx = PAL_AW'(shifted);
      default:    idx = '0;
    endcase
  end

  assign rend = (({1'b0, col} + 1'b1) >= cfg.width);
  assign fend = rend && (({1'b0, row} + 1'b1) >= cfg.height);
  assign lob  = rend || (pix_k == last_k);

  // palette writes retire at once; a data word leaves after its last pixel
  assign head_pop = head_valid && (head_item.is_palette || (advance && lob));

  always_ff @(posedge clk) begin
    if (head_valid && head_item.is_palette) begin
      pal_mem[head_item.pal_addr] <= head_item.pal_color;
    end
    if (fire) begin
      rd_color <= pal_mem[idx];
      lob_q    <= lob;
      rend_q   <= rend;
      fend_q   <= fend;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_k <= '0;
      col   <= '0;
      row   <= '0;
      ov    <= 1'b0;
    end else begin
      if (advance) begin
        ov <= fire;
      end
      if (fire) begin
        pix_k <= lob ? 3'd0 : pix_k + 1'b1;
        if (rend) begin
          col <= '0;
          row <= fend ? '0 : row + 1'b1;
        end else begin
          col <= col + 1'b1;
        end
      end
    end
  end

  assign out_valid             = ov;
  assign out_word.pixel_color  = rd_color;
  assign out_word.last_of_byte = lob_q;
  assign out_word.row_end      = rend_q;
  assign out_word.frame_end    = fend_q;

`ifndef SYNTH
  a_fend_is_rend: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_word.frame_end || out_word.row_end))
    else $error("frame end without row end");

  a_rend_is_lob: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_word.row_end || out_word.last_of_byte))
    else $error("row end not last of word");

  a_field_in_byte: assert property (@(posedge clk) disable iff (rst)
    kbits < 6'd8)
    else $error("pixel position past end of word");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");
`endif

endmodule

/* design/packed_palette_pixel_expander.sv */
// Packed palette pixel expander.
// Input channel (in_valid/in_stall/in_word): each word is either a packed
// pixel byte (1, 2, 4 or 8 bits per pixel, first pixel in the top bits) or
// a palette write that loads one RGB565 entry.
// Output channel (out_valid/out_stall/out_word): one word per pixel with its
// RGB565 color and last-of-byte, row-end and frame-end flags.
// Config port (cfg_we/cfg_index/cfg_data): 0 depth mode, 1 width, 2 height;
// write only while the block is idle.
// out_valid for the first pixel of a byte rises once the byte has passed
// through the input queue and the output register.
// Throughput: one pixel per cycle while out_stall is low, set by the single
// palette read port: 8 pixels per byte at 1 bpp, 4 at 2 bpp, 2 at 4 bpp, 1 at
// 8 bpp; a palette write gives no output. A row's leftover pixels in its
// last byte are dropped, so that byte gives fewer pixels.
// Reset: depth 8 bpp, 1x1 rectangle, counters zero, queue empty; the palette
// is not cleared and must be loaded before use.
// When out_stall is high with a word waiting, the output word holds, pixel
// generation pauses and the 2-entry input queue fills before in_stall rises.
module packed_palette_pixel_expander (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  ppe_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output ppe_pkg::out_word_t out_word,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [ppe_pkg::DIM_W-1:0] cfg_data
);
  import ppe_pkg::*;

  logic [1:0]       depth_mode;
  logic [DIM_W-1:0] rect_width;
  logic [DIM_W-1:0] rect_height;
  cfg_t             cfg;
  logic             head_valid;
  item_t            head_item;
  logic             head_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_mode  <= DEPTH_8BPP;
      rect_width  <= DIM_W'(1);
      rect_height <= DIM_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEPTH_MODE:  depth_mode  <= cfg_data[1:0];
        REG_RECT_WIDTH:  rect_width  <= cfg_data;
        REG_RECT_HEIGHT: rect_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg.depth_mode = depth_mode;
  assign cfg.width      = clamp_dim(rect_width);
  assign cfg.height     = clamp_dim(rect_height);

  ppe_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .head_valid (head_valid),
    .head_item  (head_item),
    .head_pop   (head_pop)
  );

  ppe_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head_item  (head_item),
    .head_pop   (head_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word)
  );

endmodule
